// File: design/vnorm_pkg.sv
package vnorm_pkg;

  localparam int COMP_W   = 32;
  localparam int UNIT_W   = 18;
  localparam int SUM_W    = 2 * COMP_W;
  localparam int ROOT_W   = COMP_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int SQ_STEPS = ROOT_W;
  localparam int Q_W      = 17;
  localparam int DIV_STEPS = Q_W;
  localparam int IN_W     = 3 * COMP_W;
  localparam int OUT_W    = 88;

  typedef struct packed {
    logic [2:0]        neg;
    logic [COMP_W-1:0] ax;
    logic [COMP_W-1:0] ay;
    logic [COMP_W-1:0] az;
  } comp_t;

endpackage

// File: design/vector3_normalize.sv
// channel  | dir | tdata (lsb up)                                 | tuser
// s_axis   | in  | in_x[31:0] in_y[31:0] in_z[31:0]               | -
// m_axis   | out | unit_x[17:0] unit_y[17:0] unit_z[17:0]         | zero_vector
//          |     | length[31:0], zero pad to 88 bits              |
// one vector accepted per cycle while m_axis is not stalled
// the square root takes one result bit per stage (32 stages), each of the
// three dividers one quotient bit per stage (17 stages)
// rst clears all valid bits; payload registers are not reset
// a stall on m_axis holds the whole pipeline and drops s_tready
module vector3_normalize
  import vnorm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // in_x, in_y, in_z
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // unit_x, unit_y, unit_z, length
  output logic             m_tuser    // zero_vector
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // abs stage
  logic               v0;
  comp_t              c0;
  logic [COMP_W-1:0]  in_c [3];
  logic [COMP_W-1:0]  abs_c [3];

  always_comb begin
    in_c[0] = s_tdata[COMP_W-1:0];
    in_c[1] = s_tdata[2*COMP_W-1:COMP_W];
    in_c[2] = s_tdata[3*COMP_W-1:2*COMP_W];
    for (int i = 0; i < 3; i++) begin
      abs_c[i] = in_c[i][COMP_W-1] ? (~in_c[i] + 1'b1) : in_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
    if (en) begin
      c0.neg <= {in_c[2][COMP_W-1], in_c[1][COMP_W-1], in_c[0][COMP_W-1]};
      c0.ax  <= abs_c[0];
      c0.ay  <= abs_c[1];
      c0.az  <= abs_c[2];
    end
  end

  // square stage
  logic             v1;
  comp_t            c1;
  logic [SUM_W-1:0] sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      c1    <= c0;
      sq[0] <= c0.ax * c0.ax;
      sq[1] <= c0.ay * c0.ay;
      sq[2] <= c0.az * c0.az;
    end
  end

  // sum stage feeds square root index 0
  logic             vs   [SQ_STEPS+1];
  comp_t            cs   [SQ_STEPS+1];
  logic [SUM_W-1:0] rad  [SQ_STEPS+1];
  logic [REM_W-1:0] srem [SQ_STEPS+1];
  logic [ROOT_W-1:0] root [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= v1;
    end
    if (en) begin
      cs[0]   <= c1;
      rad[0]  <= sq[0] + sq[1] + sq[2];
      srem[0] <= '0;
      root[0] <= '0;
    end
  end

  // square root, one bit per stage
  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;

    always_comb begin
      cur   = {srem[k-1], rad[k-1][SUM_W-1:SUM_W-2]};
      trial = {2'b00, root[k-1], 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= vs[k-1];
      end
      if (en) begin
        cs[k]   <= cs[k-1];
        rad[k]  <= {rad[k-1][SUM_W-3:0], 2'b00};
        srem[k] <= ge ? REM_W'(cur - trial) : REM_W'(cur);
        root[k] <= {root[k-1][ROOT_W-2:0], ge};
      end
    end
  end

  // dividers, one quotient bit per stage
  logic              vd   [1:DIV_STEPS];
  logic [2:0]        dneg [1:DIV_STEPS];
  logic [ROOT_W-1:0] dlen [1:DIV_STEPS];
  logic [ROOT_W-1:0] drem [1:DIV_STEPS][3];
  logic [Q_W-1:0]    dq   [1:DIV_STEPS][3];

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic              pv;
    logic [2:0]        pneg;
    logic [ROOT_W-1:0] plen;
    logic [ROOT_W-1:0] prem [3];
    logic [Q_W-1:0]    pq   [3];
    logic [2:0]        plsb;
    logic [ROOT_W:0]   cur [3];
    logic              ge  [3];

    if (j == 1) begin : g_src
      always_comb begin
        pv      = vs[SQ_STEPS];
        pneg    = cs[SQ_STEPS].neg;
        plen    = root[SQ_STEPS];
        prem[0] = {1'b0, cs[SQ_STEPS].ax[COMP_W-1:1]};
        prem[1] = {1'b0, cs[SQ_STEPS].ay[COMP_W-1:1]};
        prem[2] = {1'b0, cs[SQ_STEPS].az[COMP_W-1:1]};
        plsb    = {cs[SQ_STEPS].az[0], cs[SQ_STEPS].ay[0], cs[SQ_STEPS].ax[0]};
        for (int i = 0; i < 3; i++) begin
          pq[i] = '0;
        end
      end
    end else begin : g_src
      always_comb begin
        pv   = vd[j-1];
        pneg = dneg[j-1];
        plen = dlen[j-1];
        plsb = '0;
        for (int i = 0; i < 3; i++) begin
          prem[i] = drem[j-1][i];
          pq[i]   = dq[j-1][i];
        end
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cur[i] = {prem[i], plsb[i]};
        ge[i]  = cur[i] >= {1'b0, plen};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j] <= 1'b0;
      end else if (en) begin
        vd[j] <= pv;
      end
      if (en) begin
        dneg[j] <= pneg;
        dlen[j] <= plen;
        for (int i = 0; i < 3; i++) begin
          drem[j][i] <= ge[i] ? ROOT_W'(cur[i] - {1'b0, plen}) : ROOT_W'(cur[i]);
          dq[j][i]   <= {pq[i][Q_W-2:0], ge[i]};
        end
      end
    end
  end

  // output register
  logic [UNIT_W-1:0] unit [3];
  logic [UNIT_W-1:0] qx   [3];
  logic              zero;
  logic [ROOT_W-1:0] len_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i] = {1'b0, dq[DIV_STEPS][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd[DIV_STEPS];
    end
    if (en) begin
      zero    <= dlen[DIV_STEPS] == '0;
      len_out <= dlen[DIV_STEPS];
      for (int i = 0; i < 3; i++) begin
        if (dlen[DIV_STEPS] == '0) begin
          unit[i] <= '0;
        end else begin
          unit[i] <= dneg[DIV_STEPS][i] ? (~qx[i] + 1'b1) : qx[i];
        end
      end
    end
  end

  assign m_tdata = {2'b00, len_out, unit[2], unit[1], unit[0]};
  assign m_tuser = zero;

  a_zero_len : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == (m_tdata[85:54] == '0)))
    else $error("zero flag and length disagree");

  a_zero_units : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[53:0] == '0))
    else $error("zero vector with nonzero unit");

  a_q_range : assert property (@(posedge clk) disable iff (rst)
    (vd[DIV_STEPS] && dlen[DIV_STEPS] != '0)
      |-> (dq[DIV_STEPS][0] <= 17'd65536 && dq[DIV_STEPS][1] <= 17'd65536
           && dq[DIV_STEPS][2] <= 17'd65536))
    else $error("quotient out of range");

endmodule
